// ===== rtl/lzhc_pkg.sv =====
// shared types and codes for the hash chain match finder
// no dependencies
`timescale 1ns / 1ps
package lzhc_pkg;

  localparam int unsigned POS_W   = 24;
  localparam int unsigned CHAIN_W = 12;
  localparam int unsigned OUT_LEN_W = 9;

  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_INSERT = 2'd1;
  localparam logic [1:0] ACT_FIND   = 2'd2;
  localparam logic [1:0] ACT_NOP    = 2'd3;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_INSERT,
    OP_FIND
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [7:0]         byte_value;
    logic [POS_W-1:0]   position;
    logic [CHAIN_W-1:0] chain_limit;
    logic [POS_W-1:0]   encoder_pos;
  } item_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } back_status_t;

endpackage

// ===== rtl/lzhc_ram.sv =====
// generic single write, single read ram with registered read
// no dependencies
`timescale 1ns / 1ps
module lzhc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/lzhc_front.sv =====
// front end: takes commands, drops unknown actions, queues the rest
// depends on lzhc_pkg
`timescale 1ns / 1ps
module lzhc_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_action,
  input  logic [7:0]                   in_byte_value,
  input  logic [23:0]                  in_position,
  input  logic [11:0]                  in_chain_limit,
  input  logic [23:0]                  in_encoder_pos,
  input  lzhc_pkg::back_status_t       back_st,
  output logic                         q_valid,
  output lzhc_pkg::item_t              q_item
);
  import lzhc_pkg::*;

  item_t      q_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       accept;
  logic       push;
  logic       pop;
  item_t      item;

  assign busy    = back_st.clearing || (count_r == 2'd2);
  assign accept  = start && !busy;
  assign q_valid = (count_r != 2'd0);
  assign q_item  = q_r[rd_ptr_r];
  assign pop     = back_st.pop && q_valid;

  always_comb begin
    item.byte_value  = in_byte_value;
    item.position    = in_position;
    item.chain_limit = in_chain_limit;
    item.encoder_pos = in_encoder_pos;
    push             = accept;
    case (in_action)
      ACT_LOAD:   item.op = OP_LOAD;
      ACT_INSERT: item.op = OP_INSERT;
      ACT_FIND:   item.op = OP_FIND;
      default: begin
        item.op = OP_LOAD;
        push    = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        q_r[wr_ptr_r] <= item;
        wr_ptr_r      <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== rtl/lzhc_back.sv =====
// back end: sequencer for load, insert and find over the ring and chain tables
// depends on lzhc_pkg and lzhc_ram
`timescale 1ns / 1ps
module lzhc_back #(
  parameter int unsigned HASH_SIZE   = 65536,
  parameter int unsigned WINDOW_SIZE = 32768,
  parameter int unsigned MAX_MATCH   = 258,
  parameter int unsigned RING_BYTES  = 65536
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  input  lzhc_pkg::item_t        q_item,
  output lzhc_pkg::back_status_t back_st,
  input  logic                   cfg_we,
  input  logic [23:0]            cfg_data,
  output logic                   out_valid,
  output logic [23:0]            out_match_pos,
  output logic [8:0]             out_match_length
);
  import lzhc_pkg::*;

  localparam int unsigned HASH_W  = $clog2(HASH_SIZE);
  localparam int unsigned WIN_W   = $clog2(WINDOW_SIZE);
  localparam int unsigned RING_W  = $clog2(RING_BYTES);
  localparam int unsigned LEN_W   = $clog2(MAX_MATCH + 1);
  localparam int unsigned CLR_DEPTH = (HASH_SIZE > WINDOW_SIZE) ? HASH_SIZE : WINDOW_SIZE;
  localparam int unsigned CLR_W   = $clog2(CLR_DEPTH);
  localparam int unsigned ENT_W   = POS_W + 1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LOAD, S_G_RD, S_G_CAP, S_H_RD, S_H_CAP,
    S_CHECK, S_C_RD, S_C_CHK, S_NEXT
  } state_t;

  state_t              state_r;
  logic [CLR_W-1:0]    clr_cnt_r;
  logic [POS_W-1:0]    ds_r;
  item_t               it_r;
  logic [1:0]          k_r;
  logic [7:0]          ba_r [3];
  logic [7:0]          bb_r [3];
  logic [ENT_W-1:0]    node_r;
  logic [POS_W-1:0]    cand_r;
  logic [CHAIN_W-1:0]  left_r;
  logic [LEN_W-1:0]    len_r;
  logic [LEN_W-1:0]    best_len_r;
  logic [POS_W-1:0]    best_pos_r;
  logic                out_valid_r;
  logic [POS_W-1:0]    out_pos_r;
  logic [OUT_LEN_W-1:0] out_len_r;

  logic                ring_we, ring_re;
  logic [RING_W-1:0]   ring_wa, ra_addr, rb_addr;
  logic [7:0]          ra_data, rb_data;
  logic                head_we, head_re;
  logic [HASH_W-1:0]   head_wa;
  logic [ENT_W-1:0]    head_wd, head_rd;
  logic                prev_we, prev_re;
  logic [WIN_W-1:0]    prev_wa;
  logic [ENT_W-1:0]    prev_wd, prev_rd;

  logic [HASH_W-1:0]   hash;
  logic [POS_W:0]      ga_sum, gb_sum, ca_sum, cp_sum;
  logic                clr_head, clr_prev, clr_last;
  logic signed [POS_W+1:0] age;
  logic                stop;
  logic                cmp_go;
  logic                repeat3;
  logic [ENT_W-1:0]    nxt_node;

  assign hash     = HASH_W'({ba_r[0], ba_r[1], ba_r[2]});
  assign ga_sum   = {1'b0, it_r.position} + (POS_W+1)'(k_r);
  assign gb_sum   = {1'b0, it_r.position} + (POS_W+1)'(k_r) - (POS_W+1)'(3);
  assign ca_sum   = {1'b0, cand_r} + (POS_W+1)'(len_r);
  assign cp_sum   = {1'b0, it_r.position} + (POS_W+1)'(len_r);
  assign clr_head = ({1'b0, clr_cnt_r} < (CLR_W+1)'(HASH_SIZE));
  assign clr_prev = ({1'b0, clr_cnt_r} < (CLR_W+1)'(WINDOW_SIZE));
  assign clr_last = (clr_cnt_r == CLR_W'(CLR_DEPTH - 1));
  assign age      = $signed({2'b00, it_r.encoder_pos}) - $signed({2'b00, node_r[POS_W-1:0]});
  assign stop     = (left_r == '0) || !node_r[POS_W] ||
                    (age > $signed((POS_W+2)'(WINDOW_SIZE)));
  assign cmp_go   = (ca_sum < {1'b0, ds_r}) && (len_r < LEN_W'(MAX_MATCH)) &&
                    (cp_sum < {1'b0, ds_r});
  assign repeat3  = (it_r.position >= POS_W'(3)) && (ba_r[0] == bb_r[0]) &&
                    (ba_r[1] == bb_r[1]) && (ba_r[2] == bb_r[2]);
  assign nxt_node = (prev_rd[POS_W] && (prev_rd[POS_W-1:0] > cand_r)) ? '0 : prev_rd;

  assign back_st.pop      = (state_r == S_IDLE);
  assign back_st.clearing = (state_r == S_CLEAR);

  always_comb begin
    ring_we = (state_r == S_LOAD);
    ring_wa = it_r.position[RING_W-1:0];
    ring_re = (state_r == S_G_RD) || ((state_r == S_C_RD) && cmp_go);
    if (state_r == S_G_RD) begin
      ra_addr = ga_sum[RING_W-1:0];
      rb_addr = gb_sum[RING_W-1:0];
    end else begin
      ra_addr = ca_sum[RING_W-1:0];
      rb_addr = cp_sum[RING_W-1:0];
    end
    head_re = (state_r == S_H_RD);
    prev_re = (state_r == S_CHECK) && !stop;
    if (state_r == S_CLEAR) begin
      head_we = clr_head;
      head_wa = clr_cnt_r[HASH_W-1:0];
      head_wd = '0;
      prev_we = clr_prev;
      prev_wa = clr_cnt_r[WIN_W-1:0];
      prev_wd = '0;
    end else begin
      head_wa = hash;
      head_wd = {1'b1, it_r.position};
      prev_wa = it_r.position[WIN_W-1:0];
      prev_wd = head_rd;
      head_we = (state_r == S_H_CAP) && (it_r.op == OP_INSERT) &&
                (!head_rd[POS_W] || !repeat3);
      prev_we = (state_r == S_H_CAP) && (it_r.op == OP_INSERT) &&
                head_rd[POS_W] && !repeat3;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      ds_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        ds_r <= cfg_data;
      end
      case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + CLR_W'(1);
          if (clr_last) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            it_r <= q_item;
            k_r  <= 2'd0;
            case (q_item.op)
              OP_LOAD:  state_r <= S_LOAD;
              default:  state_r <= S_G_RD;
            endcase
          end
        end
        S_LOAD: state_r <= S_IDLE;
        S_G_RD: state_r <= S_G_CAP;
        S_G_CAP: begin
          ba_r[k_r] <= ra_data;
          bb_r[k_r] <= rb_data;
          k_r       <= k_r + 2'd1;
          state_r   <= (k_r == 2'd2) ? S_H_RD : S_G_RD;
        end
        S_H_RD: state_r <= S_H_CAP;
        S_H_CAP: begin
          if (it_r.op == OP_FIND) begin
            node_r     <= head_rd;
            left_r     <= it_r.chain_limit;
            best_len_r <= LEN_W'(1);
            best_pos_r <= it_r.position;
            state_r    <= S_CHECK;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_CHECK: begin
          if (stop) begin
            out_valid_r <= 1'b1;
            out_pos_r   <= best_pos_r;
            out_len_r   <= OUT_LEN_W'(best_len_r);
            state_r     <= S_IDLE;
          end else begin
            left_r  <= left_r - CHAIN_W'(1);
            cand_r  <= node_r[POS_W-1:0];
            len_r   <= '0;
            state_r <= S_C_RD;
          end
        end
        S_C_RD: state_r <= cmp_go ? S_C_CHK : S_NEXT;
        S_C_CHK: begin
          if (ra_data == rb_data) begin
            len_r   <= len_r + LEN_W'(1);
            state_r <= S_C_RD;
          end else begin
            state_r <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (len_r > best_len_r) begin
            best_len_r <= len_r;
            best_pos_r <= cand_r;
          end
          node_r  <= nxt_node;
          state_r <= S_CHECK;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_match_pos    = out_pos_r;
  assign out_match_length = out_len_r;

  lzhc_ram #(.WIDTH(8), .DEPTH(RING_BYTES)) u_ring_a (
    .clk(clk), .we(ring_we), .waddr(ring_wa), .wdata(it_r.byte_value),
    .re(ring_re), .raddr(ra_addr), .rdata(ra_data)
  );

  lzhc_ram #(.WIDTH(8), .DEPTH(RING_BYTES)) u_ring_b (
    .clk(clk), .we(ring_we), .waddr(ring_wa), .wdata(it_r.byte_value),
    .re(ring_re), .raddr(rb_addr), .rdata(rb_data)
  );

  lzhc_ram #(.WIDTH(ENT_W), .DEPTH(HASH_SIZE)) u_head (
    .clk(clk), .we(head_we), .waddr(head_wa), .wdata(head_wd),
    .re(head_re), .raddr(hash), .rdata(head_rd)
  );

  lzhc_ram #(.WIDTH(ENT_W), .DEPTH(WINDOW_SIZE)) u_prev (
    .clk(clk), .we(prev_we), .waddr(prev_wa), .wdata(prev_wd),
    .re(prev_re), .raddr(node_r[WIN_W-1:0]), .rdata(prev_rd)
  );

endmodule

// ===== rtl/lz77_hash_chain_match_finder.sv =====
// top level of the lz77 hash chain match finder
// depends on lzhc_pkg, lzhc_front, lzhc_back
`timescale 1ns / 1ps
// usage:
// a command is taken at a clock edge with start high and busy low; in_action
// selects load byte, insert position or find longest match (code 3 is ignored)
// a two entry queue sits between the command front end and the sequencer, so
// busy rises only when the queue is full or the tables are being cleared
// load writes the byte to both ring copies; insert reads the three hash bytes and
// the head entry, then may update the head and prev tables; find does the same
// reads, then per chain candidate reads the prev link and compares one byte at a
// time until a mismatch, the data size or MAX_MATCH ends the compare
// compares are paced by the one read port of each ring copy, a byte per compare
// each find gives one result on out_* for one cycle marked by out_valid;
// loads and inserts give none; the receiver cannot stall
// cfg_we writes data_size; write it only while no command is in progress
// after reset busy stays high while the head and prev tables are
// cleared to empty
// table sizes are powers of two
module lz77_hash_chain_match_finder #(
  parameter int unsigned HASH_SIZE   = 65536,
  parameter int unsigned WINDOW_SIZE = 32768,
  parameter int unsigned MAX_MATCH   = 258,
  parameter int unsigned RING_BYTES  = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_byte_value,
  input  logic [23:0] in_position,
  input  logic [11:0] in_chain_limit,
  input  logic [23:0] in_encoder_pos,
  input  logic        cfg_we,
  input  logic [23:0] cfg_data,
  output logic        out_valid,
  output logic [23:0] out_match_pos,
  output logic [8:0]  out_match_length
);
  import lzhc_pkg::*;

  back_status_t back_st;
  logic         q_valid;
  item_t        q_item;

  lzhc_front u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action), .in_byte_value(in_byte_value),
    .in_position(in_position), .in_chain_limit(in_chain_limit),
    .in_encoder_pos(in_encoder_pos), .back_st(back_st),
    .q_valid(q_valid), .q_item(q_item)
  );

  lzhc_back #(
    .HASH_SIZE(HASH_SIZE), .WINDOW_SIZE(WINDOW_SIZE),
    .MAX_MATCH(MAX_MATCH), .RING_BYTES(RING_BYTES)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_item(q_item),
    .back_st(back_st), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_match_pos(out_match_pos),
    .out_match_length(out_match_length)
  );

endmodule

// ===== rtl/lzhc_checker.sv =====
// port level checks for the match finder, bound to the top level
// depends on lz77_hash_chain_match_finder
`timescale 1ns / 1ps
module lzhc_checker (
  input logic clk,
  input logic rst_n,
  input logic busy,
  input logic out_valid
);

  a_busy_after_reset: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy low right after reset");

  a_no_result_after_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result right after reset");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held two cycles");

endmodule

bind lz77_hash_chain_match_finder lzhc_checker u_lzhc_checker (
  .clk(clk), .rst_n(rst_n), .busy(busy), .out_valid(out_valid)
);

// ===== bench/tb_lz77_hash_chain_match_finder.sv =====
// testbench for the lz77 hash chain match finder: queued driver, result monitor
// and a local predictor of the byte ring, head table and prev links
// depends on lzhc_pkg and lz77_hash_chain_match_finder
`timescale 1ns / 1ps
module tb_lz77_hash_chain_match_finder;
  import lzhc_pkg::*;

  localparam int unsigned HSZ = 65536;
  localparam int unsigned WSZ = 32768;
  localparam int unsigned MAXM = 258;
  localparam int unsigned RSZ = 65536;
  localparam longint CYCLE_LIMIT = 20000000;

  typedef struct {
    logic [1:0]  action;
    logic [7:0]  byte_value;
    logic [23:0] position;
    logic [11:0] chain_limit;
    logic [23:0] encoder_pos;
  } cmd_t;

  typedef struct {
    logic [23:0] mpos;
    logic [8:0]  mlen;
  } match_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_action;
  logic [7:0]  in_byte_value;
  logic [23:0] in_position;
  logic [11:0] in_chain_limit;
  logic [23:0] in_encoder_pos;
  logic        cfg_we;
  logic [23:0] cfg_data;
  logic        out_valid;
  logic [23:0] out_match_pos;
  logic [8:0]  out_match_length;

  cmd_t   pending_cmds[$];
  match_t expected_matches[$];
  cmd_t   cur_cmd;
  int     idle_pct;
  int     mismatches;
  longint cycles;

  // predictor state
  logic [7:0]  ring_mem[RSZ];
  bit          head_ok[HSZ];
  logic [23:0] head_pos[HSZ];
  bit          link_ok[WSZ];
  logic [23:0] link_pos[WSZ];
  logic [23:0] size_reg;

  lz77_hash_chain_match_finder uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action), .in_byte_value(in_byte_value), .in_position(in_position),
    .in_chain_limit(in_chain_limit), .in_encoder_pos(in_encoder_pos),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_match_pos(out_match_pos),
    .out_match_length(out_match_length)
  );

  always #10 clk = ~clk;

  function automatic logic [7:0] ring_byte(longint unsigned p);
    return ring_mem[p % RSZ];
  endfunction

  function automatic int unsigned hash_of(logic [23:0] p);
    logic [23:0] v;
    v = {ring_byte(p), ring_byte(p + 1), ring_byte(p + 2)};
    return v % HSZ;
  endfunction

  function automatic void chain_insert(logic [23:0] p);
    int unsigned h;
    h = hash_of(p);
    if (!head_ok[h]) begin
      head_ok[h] = 1;
      head_pos[h] = p;
      return;
    end
    if (p >= 3 && ring_byte(p) == ring_byte(p - 3) && ring_byte(p + 1) == ring_byte(p - 2)
        && ring_byte(p + 2) == ring_byte(p - 1))
      return;
    link_ok[p % WSZ] = 1;
    link_pos[p % WSZ] = head_pos[h];
    head_pos[h] = p;
  endfunction

  function automatic match_t longest_match(logic [23:0] p, logic [11:0] lim, logic [23:0] enc);
    match_t r;
    int unsigned h;
    int unsigned left;
    bit ok;
    logic [23:0] cand;
    longint unsigned len;
    longint unsigned best_len;
    logic [23:0] best_pos;
    h = hash_of(p);
    ok = head_ok[h];
    cand = head_pos[h];
    left = lim;
    best_len = 1;
    best_pos = p;
    while (left != 0 && ok && (longint'(enc) - longint'(cand) <= longint'(WSZ))) begin
      left--;
      len = 0;
      while (longint'(cand) + len < size_reg && len < MAXM && longint'(p) + len < size_reg
             && ring_byte(longint'(cand) + len) == ring_byte(longint'(p) + len))
        len++;
      if (len > best_len) begin
        best_len = len;
        best_pos = cand;
      end
      if (link_ok[cand % WSZ] && link_pos[cand % WSZ] <= cand) begin
        cand = link_pos[cand % WSZ];
      end else begin
        ok = 0;
      end
    end
    r.mpos = best_pos;
    r.mlen = best_len[8:0];
    return r;
  endfunction

  function automatic void predict(cmd_t c);
    case (c.action)
      ACT_LOAD: ring_mem[c.position % RSZ] = c.byte_value;
      ACT_INSERT: chain_insert(c.position);
      ACT_FIND: expected_matches.push_back(longest_match(c.position, c.chain_limit,
                                                         c.encoder_pos));
      default: ;
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    if (start && !busy) predict(cur_cmd);
    if (!start || !busy) begin
      if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
        cur_cmd = pending_cmds.pop_front();
        start <= 1'b1;
        in_action <= cur_cmd.action;
        in_byte_value <= cur_cmd.byte_value;
        in_position <= cur_cmd.position;
        in_chain_limit <= cur_cmd.chain_limit;
        in_encoder_pos <= cur_cmd.encoder_pos;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    match_t e;
    if (rst_n && out_valid) begin
      if (expected_matches.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result pos=%0d len=%0d", out_match_pos, out_match_length);
      end else begin
        e = expected_matches.pop_front();
        if (e.mpos !== out_match_pos || e.mlen !== out_match_length) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected pos=%0d len=%0d, got pos=%0d len=%0d",
                     e.mpos, e.mlen, out_match_pos, out_match_length);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic push_cmd(logic [1:0] a, logic [7:0] b, logic [23:0] p, logic [11:0] lim,
                          logic [23:0] enc);
    cmd_t c;
    c.action = a;
    c.byte_value = b;
    c.position = p;
    c.chain_limit = lim;
    c.encoder_pos = enc;
    pending_cmds.push_back(c);
  endtask

  task automatic drain();
    while (pending_cmds.size() != 0 || start || expected_matches.size() != 0)
      @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_size(logic [23:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    size_reg = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] rand_byte();
    if ($urandom_range(0, 99) < 75) return 8'($urandom_range(0, 3));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [11:0] rand_limit();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return 12'($urandom_range(0, 8));
    if (r < 97) return 12'($urandom_range(9, 64));
    return 12'd4095;
  endfunction

  function automatic logic [23:0] rand_enc(logic [23:0] p);
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return p + 24'($urandom_range(0, 100));
    if (r < 90) return p + 24'($urandom_range(32000, 33500));
    return 24'($urandom);
  endfunction

  // runs whose ring offsets stay in the loaded low area: reload, insert, search
  task automatic random_block(int n);
    logic [23:0] base;
    logic [23:0] p;
    int k;
    k = 0;
    while (k < n) begin
      case ($urandom_range(0, 3))
        0: base = 24'($urandom_range(0, 200));
        1: base = 24'($urandom_range(0, 20));
        2: base = 24'hFF0000 | 24'($urandom_range(0, 200));
        default: base = {8'($urandom), 16'($urandom_range(0, 200))};
      endcase
      repeat ($urandom_range(0, 6)) begin
        push_cmd(ACT_LOAD, rand_byte(), base + 24'($urandom_range(0, 40)), 12'($urandom),
                 24'($urandom));
        k++;
      end
      for (int i = 0; i < $urandom_range(8, 30); i++) begin
        push_cmd(ACT_INSERT, 8'($urandom), base + 24'(i), 12'($urandom), 24'($urandom));
        k++;
      end
      repeat ($urandom_range(2, 8)) begin
        p = base + 24'($urandom_range(0, 40));
        push_cmd(ACT_FIND, 8'($urandom), p, rand_limit(), rand_enc(p));
        k++;
      end
      if ($urandom_range(0, 9) == 0) begin
        push_cmd(ACT_NOP, 8'($urandom), 24'($urandom), 12'($urandom), 24'($urandom));
        p = {8'($urandom), 16'($urandom_range(0, 240))};
        push_cmd(ACT_FIND, 8'($urandom), p, rand_limit(), rand_enc(p));
        push_cmd(ACT_INSERT, 8'($urandom), {8'($urandom), 16'($urandom_range(0, 240))},
                 12'($urandom), 24'($urandom));
        k += 3;
      end
    end
  endtask

  initial begin
    clk = 0;
    rst_n = 0;
    start = 0;
    in_action = ACT_NOP;
    in_byte_value = 0;
    in_position = 0;
    in_chain_limit = 0;
    in_encoder_pos = 0;
    cfg_we = 0;
    cfg_data = 0;
    idle_pct = 0;
    mismatches = 0;
    cycles = 0;
    size_reg = 0;
    for (int i = 0; i < HSZ; i++) head_ok[i] = 0;
    for (int i = 0; i < WSZ; i++) link_ok[i] = 0;
    for (int i = 0; i < RSZ; i++) ring_mem[i] = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);

    // load the low ring area and the top three bytes so every later read sees loaded data
    for (int i = 0; i < 512; i++) begin
      logic [7:0] b;
      if (i >= 64 && i < 400) b = 8'h11 * 8'((i % 4) + 1);
      else if (i >= 4 && i < 44) b = 8'(5 + i % 3);
      else b = rand_byte();
      push_cmd(ACT_LOAD, b, 24'(i), 12'($urandom), 24'($urandom));
    end
    for (int i = 65533; i < 65536; i++)
      push_cmd(ACT_LOAD, rand_byte(), 24'(i), 12'($urandom), 24'($urandom));
    drain();

    // directed part
    write_size(24'hFFFFFF);
    push_cmd(ACT_LOAD, 8'hFF, 24'hFFFFFF, 12'hFFF, 24'hFFFFFF);
    push_cmd(ACT_LOAD, 8'h00, 24'h00FFFE, 12'h000, 24'h000000);
    push_cmd(ACT_INSERT, 8'h00, 24'd0, 12'd0, 24'd0);
    push_cmd(ACT_INSERT, 8'h00, 24'd1, 12'd0, 24'd0);
    push_cmd(ACT_INSERT, 8'h00, 24'd2, 12'd0, 24'd0);
    push_cmd(ACT_INSERT, 8'h00, 24'hFFFFFE, 12'd0, 24'd0);
    push_cmd(ACT_FIND, 8'h00, 24'd0, 12'd0, 24'd0);
    push_cmd(ACT_FIND, 8'h00, 24'd2, 12'd4095, 24'd2);
    push_cmd(ACT_NOP, 8'hFF, 24'hFFFFFF, 12'hFFF, 24'hFFFFFF);
    for (int i = 64; i < 104; i++) push_cmd(ACT_INSERT, 8'h00, 24'(i), 12'd0, 24'd0);
    push_cmd(ACT_FIND, 8'h00, 24'd104, 12'd4095, 24'd104);
    push_cmd(ACT_FIND, 8'h00, 24'd104, 12'd1, 24'd104);
    push_cmd(ACT_FIND, 8'h00, 24'd104, 12'd8, 24'd33104);
    push_cmd(ACT_INSERT, 8'h00, 24'd7, 12'd0, 24'd0);
    push_cmd(ACT_INSERT, 8'h00, 24'd10, 12'd0, 24'd0);
    push_cmd(ACT_FIND, 8'h00, 24'd13, 12'd16, 24'd13);
    push_cmd(ACT_INSERT, 8'h00, 24'd64 + 24'd65536, 12'd0, 24'd0);
    push_cmd(ACT_FIND, 8'h00, 24'd100, 12'd4095, 24'd100);
    push_cmd(ACT_FIND, 8'h00, 24'd5, 12'd3, 24'hFFFFFF);
    drain();
    write_size(24'd0);
    push_cmd(ACT_FIND, 8'h00, 24'd104, 12'd4095, 24'd104);
    push_cmd(ACT_FIND, 8'h00, 24'd100, 12'd10, 24'd100);
    drain();
    write_size(24'd300);
    push_cmd(ACT_FIND, 8'h00, 24'd104, 12'd64, 24'd104);
    drain();

    // random part over several sizes and idle settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_size(24'hFFFFFF);
        1: write_size(24'd0);
        2: write_size(24'($urandom_range(500, 70000)));
        3: write_size(24'($urandom));
        4: write_size(24'd65536);
        default: write_size(24'hFFFFFF);
      endcase
      case (ph % 3)
        0: idle_pct = 0;
        1: idle_pct = 81;
        default: idle_pct = 22;
      endcase
      random_block(45);
      drain();
    end

    if (mismatches == 0 && expected_matches.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/lzhc_pkg.sv
rtl/lzhc_ram.sv
rtl/lzhc_front.sv
rtl/lzhc_back.sv
rtl/lz77_hash_chain_match_finder.sv
rtl/lzhc_checker.sv
bench/tb_lz77_hash_chain_match_finder.sv
